// ----- rtl/core/srf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants of the Sellmeier index block
// Field widths, fixed-point scales, status codes and register indexes.
// ----------------------------------------------------------------------------
package srf_pkg;

  // field widths
  localparam int WAVE_W     = 20;
  localparam int COEF_B_W   = 32;
  localparam int COEF_C_W   = 40;
  localparam int INDEX_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int NUM_TERMS  = 3;

  // fixed-point scales
  localparam int COEF_FRAC_BITS = 28;
  localparam int C_FRAC_BITS    = 32;

  // accumulator and unit widths
  localparam int ACC_W      = 64;
  localparam int TERM_QBITS = 61;          // term quotient bits, saturates at 2^60
  localparam int SQRT_IN_W  = 2 * INDEX_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // parameter defaults
  localparam int WAVE_FRAC_BITS_DEF  = 16;
  localparam int INDEX_FRAC_BITS_DEF = 28;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_POLE    = 2'd1,
    STATUS_NEG_RAD = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B1 = 3'd0,
    REG_B2 = 3'd1,
    REG_B3 = 3'd2,
    REG_C1 = 3'd3,
    REG_C2 = 3'd4,
    REG_C3 = 3'd5
  } cfg_reg_e;

endpackage

// ----- rtl/core/srf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_front: input stage
// Squares the wavelength, aligns it to the C scale, flags poles and
// pushes the word into the queue.
// ----------------------------------------------------------------------------
module srf_front import srf_pkg::*; #(
  parameter int WAVE_FRAC_BITS = WAVE_FRAC_BITS_DEF,
  parameter int L2W            = 40
) (
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [WAVE_W-1:0]                   wavelength_um_i,
  input  logic [NUM_TERMS-1:0][COEF_C_W-1:0]  coef_c_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [L2W-1:0]                      l2_o,
  output logic                                pole_o
);

  localparam int LSH = C_FRAC_BITS - 2 * WAVE_FRAC_BITS;

  logic [2*WAVE_W-1:0] sq;

  // handshake into the queue
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i & !q_full_i;

  assign sq = wavelength_um_i * wavelength_um_i;

  // align L^2 to 32 fraction bits
  if (LSH >= 0) begin : g_lsh
    assign l2_o = L2W'(sq) << LSH;
  end else begin : g_rsh
    assign l2_o = L2W'(sq >> (-LSH));
  end

  // pole when L^2 hits any resonance term
  always_comb begin
    pole_o = 1'b0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (l2_o == L2W'(coef_c_i[k])) pole_o = 1'b1;
    end
  end

endmodule

// ----- rtl/core/srf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_fifo: short queue between front and back
// Lets the front keep accepting while the back pipeline is stalled.
// ----------------------------------------------------------------------------
module srf_fifo import srf_pkg::*; #(
  parameter int W = 41
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]   mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- rtl/core/srf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_div: pipelined restoring divider
// One quotient bit per stage; quotient saturates at 2^60.
// ----------------------------------------------------------------------------
module srf_div import srf_pkg::*; #(
  parameter int PW = 72,
  parameter int DW = 40,
  parameter int SW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [PW-1:0]         num_i,
  input  logic [DW-1:0]         den_i,
  input  logic [SW-1:0]         side_i,
  output logic                  valid_o,
  output logic [TERM_QBITS-1:0] quo_o,
  output logic [SW-1:0]         side_o
);

  localparam int QB = TERM_QBITS;
  localparam int NS = QB + 1;
  localparam logic [QB-1:0] SAT_VAL = QB'(1) << (QB - 1);

  logic [NS:0]     valid_q;
  logic [DW-1:0]   rem_q  [NS];
  logic [QB-1:0]   low_q  [NS];
  logic [QB-1:0]   quo_q  [NS];
  logic [DW-1:0]   den_q  [NS];
  logic [NS-1:0]   sat_q;
  logic [SW-1:0]   side_q [NS];
  logic [QB-1:0]   quo_out_q;
  logic [SW-1:0]   side_out_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-1:0], valid_i};
    end
  end

  // entry: early saturation when the high part already reaches the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(num_i >> QB);
      low_q[0]  <= num_i[QB-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      sat_q[0]  <= (num_i >> QB) >= PW'(den_i);
      side_q[0] <= side_i;
    end
  end

  // one compare-subtract per stage
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_q[s-1], low_q[s-1][QB-s]};
    assign ge = sh >= {1'b0, den_q[s-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? DW'(sh - {1'b0, den_q[s-1]}) : DW'(sh);
        quo_q[s]  <= {quo_q[s-1][QB-2:0], ge};
        low_q[s]  <= low_q[s-1];
        den_q[s]  <= den_q[s-1];
        sat_q[s]  <= sat_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // clamp at 2^60
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_out_q  <= (sat_q[QB] || (quo_q[QB] > SAT_VAL)) ? SAT_VAL : quo_q[QB];
      side_out_q <= side_q[QB];
    end
  end

  assign valid_o = valid_q[NS];
  assign quo_o   = quo_out_q;
  assign side_o  = side_out_q;

endmodule

// ----- rtl/core/srf_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_isqrt: pipelined integer square root
// Digit-by-digit floor root, one result bit per stage.
// ----------------------------------------------------------------------------
module srf_isqrt import srf_pkg::*; #(
  parameter int SW = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [SQRT_IN_W-1:0] x_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [INDEX_W-1:0]   root_o,
  output logic [SW-1:0]        side_o
);

  localparam int NST = INDEX_W;
  localparam int RW  = INDEX_W + 2;
  localparam int XW  = SQRT_IN_W;

  logic [NST:0]         valid_q;
  logic [XW-1:0]        x_q    [NST+1];
  logic [RW-1:0]        r_q    [NST+1];
  logic [INDEX_W-1:0]   root_q [NST+1];
  logic [SW-1:0]        side_q [NST+1];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NST-1:0], valid_i};
    end
  end

  // entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_i;
      r_q[0]    <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  // bring down two radicand bits, try 4*root+1
  for (genvar s = 1; s <= NST; s++) begin : g_step
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;
    logic          ge;
    assign sh    = {r_q[s-1], x_q[s-1][XW-1-2*(s-1) -: 2]};
    assign trial = (RW+2)'({root_q[s-1], 2'b01});
    assign ge    = sh >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= ge ? RW'(sh - trial) : RW'(sh);
        root_q[s] <= {root_q[s-1][INDEX_W-2:0], ge};
        x_q[s]    <= x_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[NST];
  assign root_o  = root_q[NST];
  assign side_o  = side_q[NST];

endmodule

// ----- rtl/core/srf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_back: evaluation pipeline
// Multiplies, divides the three terms, sums, takes the root and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module srf_back import srf_pkg::*; #(
  parameter int L2W             = 40,
  parameter int INDEX_FRAC_BITS = INDEX_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  logic [L2W-1:0]                     l2_i,
  input  logic                               pole_i,
  output logic                               pop_o,
  input  logic [NUM_TERMS-1:0][COEF_B_W-1:0] coef_b_i,
  input  logic [NUM_TERMS-1:0][COEF_C_W-1:0] coef_c_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [INDEX_W-1:0]                 refractive_index_o,
  output logic [STATUS_W-1:0]                status_o
);

  localparam int DW   = L2W;
  localparam int PW   = COEF_B_W + L2W;
  localparam int HI_W = L2W - 32;
  localparam int SSH  = 2 * INDEX_FRAC_BITS - COEF_FRAC_BITS;

  logic en;

  // stage 0: word taken from the queue
  logic           s0_valid_q, s0_pole_q;
  logic [L2W-1:0] s0_l2_q;

  // stage 1: partial products
  logic                                s1_valid_q, s1_pole_q;
  logic [NUM_TERMS-1:0][63:0]          pp_lo_q;
  logic [NUM_TERMS-1:0][L2W-1:0]       pp_hi_q;
  logic [NUM_TERMS-1:0][DW-1:0]        dmag1_q;
  logic [NUM_TERMS-1:0]                neg1_q;

  // stage 2: full products
  logic                                s2_valid_q, s2_pole_q;
  logic [NUM_TERMS-1:0][PW-1:0]        prod_q;
  logic [NUM_TERMS-1:0][DW-1:0]        dmag2_q;
  logic [NUM_TERMS-1:0]                neg2_q;

  logic [NUM_TERMS-1:0][COEF_B_W-1:0]  bmag;
  logic [NUM_TERMS-1:0][DW-1:0]        dmag;
  logic [NUM_TERMS-1:0]                bneg, dneg;

  logic [NUM_TERMS-1:0]                  dv_valid, dv_pole, dv_neg;
  logic [NUM_TERMS-1:0][TERM_QBITS-1:0]  dv_quo;

  logic                     sum_valid_q, sum_pole_q;
  logic signed [ACC_W-1:0]  acc, acc_q;

  logic                     ovf;
  status_e                  cls_status;
  logic [SQRT_IN_W-1:0]     sq_x;

  logic                 sr_valid;
  logic [INDEX_W-1:0]   sr_root;
  logic [2:0]           sr_side;

  logic                 out_valid_q;
  logic [INDEX_W-1:0]   index_q;
  status_e              status_q;

  // whole pipeline moves when the output register is free
  assign en    = !out_valid_q | out_ready_i;
  assign pop_o = en & q_valid_i;

  // valid bits of the front, sum and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= q_valid_i;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      sum_valid_q <= &dv_valid;
      out_valid_q <= sr_valid;
    end
  end

  // magnitudes and signs of B and (L^2 - C)
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      bneg[k] = coef_b_i[k][COEF_B_W-1];
      bmag[k] = bneg[k] ? (COEF_B_W'(0) - coef_b_i[k]) : coef_b_i[k];
      dneg[k] = s0_l2_q < DW'(coef_c_i[k]);
      dmag[k] = dneg[k] ? (DW'(coef_c_i[k]) - s0_l2_q) : (s0_l2_q - DW'(coef_c_i[k]));
    end
  end

  // data registers of stages 0..2
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_l2_q   <= l2_i;
      s0_pole_q <= pole_i;
      s1_pole_q <= s0_pole_q;
      s2_pole_q <= s1_pole_q;
      for (int k = 0; k < NUM_TERMS; k++) begin
        pp_lo_q[k] <= bmag[k] * s0_l2_q[31:0];
        pp_hi_q[k] <= bmag[k] * s0_l2_q[L2W-1 -: HI_W];
        dmag1_q[k] <= dmag[k];
        neg1_q[k]  <= bneg[k] ^ dneg[k];
        prod_q[k]  <= PW'(pp_lo_q[k]) + (PW'(pp_hi_q[k]) << 32);
        dmag2_q[k] <= dmag1_q[k];
        neg2_q[k]  <= neg1_q[k];
      end
    end
  end

  // one divider per term
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    srf_div #(
      .PW (PW),
      .DW (DW),
      .SW (2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s2_valid_q),
      .num_i   (prod_q[k]),
      .den_i   (dmag2_q[k]),
      .side_i  ({s2_pole_q, neg2_q[k]}),
      .valid_o (dv_valid[k]),
      .quo_o   (dv_quo[k]),
      .side_o  ({dv_pole[k], dv_neg[k]})
    );
  end

  // 1 + signed sum of the terms
  always_comb begin
    acc = ACC_W'(1) << COEF_FRAC_BITS;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (dv_neg[k]) acc = acc - ACC_W'(dv_quo[k]);
      else           acc = acc + ACC_W'(dv_quo[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q      <= acc;
      sum_pole_q <= |dv_pole;
    end
  end

  // classify and scale the radicand
  assign ovf  = (acc_q >> (ACC_W - SSH)) != '0;
  assign sq_x = SQRT_IN_W'(acc_q << SSH);

  always_comb begin
    if (sum_pole_q)             cls_status = STATUS_POLE;
    else if (acc_q[ACC_W-1])    cls_status = STATUS_NEG_RAD;
    else                        cls_status = STATUS_OK;
  end

  srf_isqrt #(
    .SW (3)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_valid_q),
    .x_i     (sq_x),
    .side_i  ({ovf, cls_status}),
    .valid_o (sr_valid),
    .root_o  (sr_root),
    .side_o  (sr_side)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_e'(sr_side[STATUS_W-1:0]);
      if (status_e'(sr_side[STATUS_W-1:0]) != STATUS_OK) index_q <= '0;
      else if (sr_side[2])                                 index_q <= '1;
      else                                                 index_q <= sr_root;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign refractive_index_o = index_q;
  assign status_o           = status_q;

endmodule

// ----- rtl/core/sellmeier_refractive_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sellmeier_refractive_index: three-term Sellmeier index, fixed point
// n = sqrt(1 + sum Bk*L^2/(L^2 - Ck)), with pole and negative-radicand flags.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i/in_ready_o, wavelength| sink
//   out     | out_valid_o/out_ready_i, index,  | source
//           | status                           |
//   cfg     | cfg_valid_i/cfg_ready_o, index,  | sink
//           | data                             |
//
// One word in and one word out per cycle sustained while the output is not stalled.
// Latency is set by the 61-stage term dividers and the 32-stage
// square-root pipeline plus multiply, sum and queue stages.
// Reset clears the coefficients to zero and empties the pipeline.
// A stalled output freezes the back pipeline; the two-entry queue keeps
// the input side accepting until it fills.
// ----------------------------------------------------------------------------
module sellmeier_refractive_index import srf_pkg::*; #(
  parameter int WAVE_FRAC_BITS  = WAVE_FRAC_BITS_DEF,
  parameter int INDEX_FRAC_BITS = INDEX_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [WAVE_W-1:0]     wavelength_um_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INDEX_W-1:0]    refractive_index_o,
  output logic [STATUS_W-1:0]   status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LSH = C_FRAC_BITS - 2 * WAVE_FRAC_BITS;
  localparam int L2W = 2 * WAVE_W + ((LSH > 0) ? LSH : 0);

  logic [NUM_TERMS-1:0][COEF_B_W-1:0] coef_b_q;
  logic [NUM_TERMS-1:0][COEF_C_W-1:0] coef_c_q;

  logic           q_full, q_push, q_pop, q_valid, pole;
  logic [L2W-1:0] l2;
  logic [L2W:0]   q_rd;

  // coefficient registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b_q <= '0;
      coef_c_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_B1:  coef_b_q[0] <= cfg_data_i[COEF_B_W-1:0];
        REG_B2:  coef_b_q[1] <= cfg_data_i[COEF_B_W-1:0];
        REG_B3:  coef_b_q[2] <= cfg_data_i[COEF_B_W-1:0];
        REG_C1:  coef_c_q[0] <= cfg_data_i[COEF_C_W-1:0];
        REG_C2:  coef_c_q[1] <= cfg_data_i[COEF_C_W-1:0];
        REG_C3:  coef_c_q[2] <= cfg_data_i[COEF_C_W-1:0];
        default: ;
      endcase
    end
  end

  srf_front #(
    .WAVE_FRAC_BITS (WAVE_FRAC_BITS),
    .L2W            (L2W)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .wavelength_um_i (wavelength_um_i),
    .coef_c_i        (coef_c_q),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .l2_o            (l2),
    .pole_o          (pole)
  );

  srf_fifo #(
    .W (L2W + 1)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({pole, l2}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rd)
  );

  srf_back #(
    .L2W             (L2W),
    .INDEX_FRAC_BITS (INDEX_FRAC_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .l2_i               (q_rd[L2W-1:0]),
    .pole_i             (q_rd[L2W]),
    .pop_o              (q_pop),
    .coef_b_i           (coef_b_q),
    .coef_c_i           (coef_c_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .refractive_index_o (refractive_index_o),
    .status_o           (status_o)
  );

endmodule

// ----- rtl/core/srf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_checker: port-level checks of the Sellmeier index block
// Output word stability and status/index consistency.
// ----------------------------------------------------------------------------
module srf_checker import srf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [WAVE_W-1:0]     wavelength_um_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [INDEX_W-1:0]    refractive_index_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // a held output word does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(refractive_index_o)
      && $stable(status_o))
    else $error("output word changed while stalled");

  // error status always comes with a zero index
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_POLE || status_o == STATUS_NEG_RAD)
      |-> refractive_index_o == '0)
    else $error("nonzero index with error status");

  // no undefined status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // register port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind sellmeier_refractive_index srf_checker u_srf_checker (.*);

// ----- test/sellmeier_refractive_index_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sellmeier_refractive_index_checker: index predictor and result scoreboard
// Tracks coefficient writes and accepted wavelength words. It predicts
// index and status for each word and compares them in order with the
// words the block sends out.
// ----------------------------------------------------------------------------
module sellmeier_refractive_index_checker import srf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [WAVE_W-1:0]     wavelength_um_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [INDEX_W-1:0]    refractive_index_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    status_e            status;
  } index_word_t;

  localparam int L2_SHIFT  = C_FRAC_BITS - 2 * WAVE_FRAC_BITS_DEF;
  localparam int RAD_SHIFT = 2 * INDEX_FRAC_BITS_DEF - COEF_FRAC_BITS;
  localparam logic [127:0] TERM_SAT = 128'd1 << (TERM_QBITS - 1);

  logic [COEF_B_W-1:0] strength_q[NUM_TERMS];
  logic [COEF_C_W-1:0] resonance_q[NUM_TERMS];
  index_word_t         index_fifo[$];
  int                  fails;

  assign fail_count_o = fails;
  assign pending_o    = index_fifo.size();

  // floor square root of a 64-bit radicand
  function automatic logic [INDEX_W-1:0] floor_sqrt(logic [63:0] rad);
    logic [INDEX_W-1:0] root;
    logic [INDEX_W-1:0] trial;
    root = '0;
    for (int i = INDEX_W - 1; i >= 0; i--) begin
      trial = root | (INDEX_W'(1) << i);
      if (64'(trial) * 64'(trial) <= rad) root = trial;
    end
    return root;
  endfunction

  // index for one wavelength under the current coefficients
  function automatic index_word_t calc_index(logic [WAVE_W-1:0] wl);
    index_word_t         res;
    logic [63:0]         l2;
    logic [COEF_B_W-1:0] bmag;
    logic [63:0]         dmag;
    logic [127:0]        quo;
    logic                bneg;
    logic                dneg;
    longint              acc;
    logic [63:0]         rad;
    l2 = 64'(wl) * 64'(wl);
    if (L2_SHIFT >= 0) l2 = l2 << L2_SHIFT;
    else l2 = l2 >> (-L2_SHIFT);
    // a pole on any term wins over everything else
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (l2 == 64'(resonance_q[k])) begin
        res.index  = '0;
        res.status = STATUS_POLE;
        return res;
      end
    end
    acc = longint'(1) << COEF_FRAC_BITS;
    for (int k = 0; k < NUM_TERMS; k++) begin
      bneg = strength_q[k][COEF_B_W-1];
      bmag = bneg ? -strength_q[k] : strength_q[k];
      dneg = l2 < 64'(resonance_q[k]);
      dmag = dneg ? 64'(resonance_q[k]) - l2 : l2 - 64'(resonance_q[k]);
      quo  = (128'(bmag) * 128'(l2)) / 128'(dmag);
      if (quo > TERM_SAT) quo = TERM_SAT;
      if (bneg != dneg) acc -= longint'(quo[63:0]);
      else acc += longint'(quo[63:0]);
    end
    if (acc < 0) begin
      res.index  = '0;
      res.status = STATUS_NEG_RAD;
      return res;
    end
    rad = 64'(acc);
    res.status = STATUS_OK;
    if (RAD_SHIFT >= 0) begin
      if (RAD_SHIFT > 0 && (rad >> (64 - RAD_SHIFT)) != 0) begin
        res.index = '1;
        return res;
      end
      rad = rad << RAD_SHIFT;
    end else begin
      rad = rad >> (-RAD_SHIFT);
    end
    res.index = floor_sqrt(rad);
    return res;
  endfunction

  // coefficient shadow, predictions and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    index_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        strength_q[k]  <= '0;
        resonance_q[k] <= '0;
      end
      index_fifo.delete();
      fails <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_B1: strength_q[0] <= cfg_data_i[COEF_B_W-1:0];
          REG_B2: strength_q[1] <= cfg_data_i[COEF_B_W-1:0];
          REG_B3: strength_q[2] <= cfg_data_i[COEF_B_W-1:0];
          REG_C1: resonance_q[0] <= cfg_data_i[COEF_C_W-1:0];
          REG_C2: resonance_q[1] <= cfg_data_i[COEF_C_W-1:0];
          REG_C3: resonance_q[2] <= cfg_data_i[COEF_C_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) index_fifo.push_back(calc_index(wavelength_um_i));
      if (out_valid_i && out_ready_i) begin
        if (index_fifo.size() == 0) begin
          if (fails < 10) $display("ERROR: unexpected word index=%h status=%0d",
                                   refractive_index_i, status_i);
          fails <= fails + 1;
        end else begin
          want = index_fifo.pop_front();
          if (want.index !== refractive_index_i || want.status !== status_i) begin
            if (fails < 10)
              $display("ERROR: expected index=%h status=%0d, got index=%h status=%0d",
                       want.index, want.status, refractive_index_i, status_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/sellmeier_refractive_index_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sellmeier_refractive_index_test: stimulus and verdict for the index block
// Runs ten coefficient settings (reset values, a glass-like set, poles at
// the field extremes, negative radicand, overflow, random sets) with random
// stalls on both sides; random wavelengths in all, directed in phases 0-4.
// ----------------------------------------------------------------------------
module sellmeier_refractive_index_test;
  import srf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int NUM_PHASES = 10;
  localparam int RAND_ITEMS = 95;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [WAVE_W-1:0]     wavelength_um_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [INDEX_W-1:0]    refractive_index_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    fail_count;
  int                    pending;

  logic                  quiet = 1'b0;
  logic [WAVE_W-1:0]     pole_wl[NUM_TERMS];
  int                    words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sellmeier_refractive_index dut (.*);

  sellmeier_refractive_index_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .wavelength_um_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .refractive_index_i(refractive_index_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(logic [31:0] b1, logic [31:0] b2, logic [31:0] b3,
                            logic [39:0] c1, logic [39:0] c2, logic [39:0] c3);
    write_reg(REG_B1, {8'($urandom), b1});
    write_reg(REG_B2, 40'(b2));
    write_reg(REG_B3, 40'(b3));
    write_reg(REG_C1, c1);
    write_reg(REG_C2, c2);
    write_reg(REG_C3, c3);
    // unmapped indexes must leave the coefficients alone
    write_reg(REG_SPARE_A, {8'($urandom), 32'($urandom)});
    write_reg(REG_SPARE_B, {8'($urandom), 32'($urandom)});
  endtask

  // idle gaps before about one word in nine, none in the quiet phase
  task automatic send_wl(logic [WAVE_W-1:0] wl);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    wavelength_um_i <= wl;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [WAVE_W-1:0] pick_wl();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, NUM_TERMS - 1);
    if (sel < 65) return WAVE_W'($urandom);
    if (sel < 85) return pole_wl[k] + WAVE_W'($urandom_range(0, 2)) - WAVE_W'(1);
    return WAVE_W'($urandom_range(0, 1023));
  endfunction

  initial begin
    logic [WAVE_W-1:0] w0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph == 6);
      pole_wl[0] = '0; pole_wl[1] = 20'h10000; pole_wl[2] = '1;
      case (ph)
        0: begin
          // reset coefficients: index is exactly one, zero wavelength is a pole
          send_wl('0); send_wl(20'd1); send_wl('1); send_wl(20'h10000);
        end
        1: begin
          // glass-like set with a far infrared resonance
          load_coefs(32'd279070000, 32'd62222000, 32'd271247000,
                     40'd25772800, 40'd85976000, 40'd444787000000);
          send_wl(20'h09000); send_wl(20'h10000); send_wl('1); send_wl(20'd1);
        end
        2: begin
          // poles at one micron, at the longest wavelength, and extreme B
          load_coefs(32'h7FFFFFFF, 32'h80000000, 32'h10000000,
                     40'h0100000000, 40'hFFFFFFFFFF, 40'hFFFFE00001);
          send_wl(20'h10000); send_wl('1); send_wl(20'hFFFFE);
          send_wl(20'h10001); send_wl(20'h0FFFF); send_wl('0);
        end
        3: begin
          // B1 of minus two makes the radicand negative
          load_coefs(32'hE0000000, 32'h0, 32'h0, 40'h0, 40'h0, 40'h0);
          send_wl('0); send_wl(20'd1); send_wl('1);
        end
        4: begin
          // denominator of one: the term saturates and so does the index
          load_coefs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     40'hFFFFFFFFFF, 40'h00FFFFFFFF, 40'd1);
          send_wl(20'h10000); send_wl(20'd1); send_wl(20'd2); send_wl(20'h0FFFF);
        end
        default: begin
          for (int k = 0; k < NUM_TERMS; k++) pole_wl[k] = WAVE_W'($urandom);
          w0 = pole_wl[0];
          load_coefs($urandom, $urandom_range(0, 32'h3FFFFFFF),
                     (ph % 2) ? $urandom : $urandom_range(0, 32'h1FFFFFFF),
                     40'(w0) * 40'(w0), {8'($urandom_range(0, 255)), 32'($urandom)},
                     40'(pole_wl[2]) * 40'(pole_wl[2]));
        end
      endcase
      for (int i = 0; i < RAND_ITEMS; i++) send_wl(pick_wl());
      drain();
    end
    $display("Run covered %0d wavelength words over %0d coefficient settings,",
             words_sent, NUM_PHASES);
    $display("with poles, negative radicands, saturation and random stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sellmeier_refractive_index.f -----
rtl/core/srf_pkg.sv
rtl/core/srf_front.sv
rtl/core/srf_fifo.sv
rtl/core/srf_div.sv
rtl/core/srf_isqrt.sv
rtl/core/srf_back.sv
rtl/core/sellmeier_refractive_index.sv
rtl/core/srf_checker.sv
test/sellmeier_refractive_index_checker.sv
test/sellmeier_refractive_index_test.sv
